FILE: hdl/pty_line_discipline_macros.svh
// Assertion macros for the pseudoterminal engine source pty_line_discipline.
`ifndef PTY_LINE_DISCIPLINE_MACROS_SVH
`define PTY_LINE_DISCIPLINE_MACROS_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define PTY_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define PTY_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hdl/pty_pkg.sv
// Types, constants and helpers for the pseudoterminal byte engine.
package pty_pkg;
   localparam int RING_DEPTH = 4096;
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int FILL_W     = AW + 1;
   localparam int SUM_W      = (AW + 2 > 13) ? AW + 2 : 13;

   localparam logic [1:0] OP_MASTER_WRITE = 2'd0;
   localparam logic [1:0] OP_SLAVE_WRITE  = 2'd1;
   localparam logic [1:0] OP_MASTER_READ  = 2'd2;
   localparam logic [1:0] OP_SLAVE_READ   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_EOF   = 2'd2;

   localparam logic [3:0] REG_MAP_CR_TO_NL   = 4'd0;
   localparam logic [3:0] REG_MAP_NL_TO_CR   = 4'd1;
   localparam logic [3:0] REG_OUT_NL_TO_CRNL = 4'd2;
   localparam logic [3:0] REG_CANONICAL_MODE = 4'd3;
   localparam logic [3:0] REG_ECHO_ENABLE    = 4'd4;
   localparam logic [3:0] REG_ERASE_CHAR     = 4'd5;
   localparam logic [3:0] REG_KILL_CHAR      = 4'd6;
   localparam logic [3:0] REG_EOF_CHAR       = 4'd7;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  read_data;
      logic [11:0] master_pending;
      logic [12:0] slave_pending;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_SECOND, ST_POP_WAIT, ST_SCAN_RD, ST_SCAN_CHK,
      ST_ASM_RD, ST_ASM_CHK, ST_FIN, ST_RESP
   } state_type;

   typedef enum logic [1:0] {SRC_OUT, SRC_IN, SRC_LINE} src_type;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      return (i == AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [FILL_W-1:0] ring_fill(input logic [AW-1:0] head,
                                                   input logic [AW-1:0] tail);
      return (head >= tail) ? {1'b0, head} - {1'b0, tail}
                            : {1'b0, head} + FILL_W'(RING_DEPTH) - {1'b0, tail};
   endfunction
endpackage

FILE: hdl/pty_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pty_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: hdl/pty_line_discipline.sv
// Pseudoterminal byte engine: two rings, echo and canonical line editing.
//
// Usage
//   Commands: req_payload (opcode, data) is taken on a rising edge with start
//   high and busy low. busy stays high until the result has been shown.
//   Results: rsp_payload is valid for exactly one cycle with rsp_valid; the
//   receiver cannot stall, so the transfer completes in that cycle.
//   Configuration: csr_index / csr_data are written on csr_valid (csr_ready
//   is always high); write only while busy is low. Indexes above 7 ignored.
// Sequence of states (from accept to the result transfer)
//   writes: EXEC then RESP, with SECOND between them when a second byte (echo
//   pair, CR before LF) goes out; pops and held-line reads: EXEC, POP_WAIT,
//   RESP. busy drops in the cycle after the strobe; no command is taken meanwhile.
//   canonical read needing a new line: SCAN_RD/SCAN_CHK per byte scanned up to
//   the terminator, ASM_RD/ASM_CHK per byte assembled, then FIN, POP_WAIT, RESP;
//   an empty line goes from FIN to RESP. No complete line: the scan, then RESP.
//   Each scanned or assembled byte is a memory read then a check.
// Reset
//   Synchronous. Ring pointers, line length and position clear and the
//   registers take their defaults; memory contents stay undefined and need
//   no clearing pass, as nothing is read that was not written first.
module pty_line_discipline (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pty_pkg::req_type req_payload,
   output logic             rsp_valid,
   output pty_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [7:0]       csr_data
);
`include "pty_line_discipline_macros.svh"

   // termios-like settings
   logic map_cr_ff, map_nl_ff, crnl_ff, canon_ff, echo_ff;
   logic [7:0] erase_ff, kill_ff, eof_ff;

   pty_pkg::state_type state_ff, state_in;
   pty_pkg::src_type   src_ff, src_in;
   logic [pty_pkg::AW-1:0] in_head_ff, in_head_in, in_tail_ff, in_tail_in;
   logic [pty_pkg::AW-1:0] out_head_ff, out_head_in, out_tail_ff, out_tail_in;
   logic [pty_pkg::AW-1:0] len_ff, len_in, pos_ff, pos_in, scan_idx_ff, scan_idx_in;
   logic [pty_pkg::FILL_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [1:0] op_ff, op_in, status_ff, status_in;
   logic [7:0] data_ff, data_in, second_ff, second_in, rd_ff, rd_in;

   // memory ports
   logic                   in_we, out_we, line_we;
   logic [pty_pkg::AW-1:0] in_waddr, out_waddr, line_waddr;
   logic [pty_pkg::AW-1:0] in_raddr, out_raddr, line_raddr;
   logic [7:0]             in_wdata, out_wdata, line_wdata;
   logic [7:0]             in_rdata, out_rdata, line_rdata;

   logic [pty_pkg::FILL_W-1:0] in_fill, out_fill;
   logic in_full, out_full;
   logic [7:0] mapped, echo1, echo2;
   logic echo_two;
   logic [pty_pkg::SUM_W-1:0] slave_sum, master_sum;

   pty_ram #(.WIDTH(8), .DEPTH(pty_pkg::RING_DEPTH)) u_input_ring (
      .clock(clock), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
      .raddr(in_raddr), .rdata(in_rdata));
   pty_ram #(.WIDTH(8), .DEPTH(pty_pkg::RING_DEPTH)) u_output_ring (
      .clock(clock), .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
      .raddr(out_raddr), .rdata(out_rdata));
   pty_ram #(.WIDTH(8), .DEPTH(pty_pkg::RING_DEPTH)) u_line_store (
      .clock(clock), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
      .raddr(line_raddr), .rdata(line_rdata));

   assign in_fill  = pty_pkg::ring_fill(in_head_ff, in_tail_ff);
   assign out_fill = pty_pkg::ring_fill(out_head_ff, out_tail_ff);
   assign in_full  = in_fill >= pty_pkg::FILL_W'(pty_pkg::RING_DEPTH - 1);
   assign out_full = out_fill >= pty_pkg::FILL_W'(pty_pkg::RING_DEPTH - 1);

   assign busy      = (state_ff != pty_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == pty_pkg::ST_RESP);
   assign csr_ready = 1'b1;

   // pending counts, masked to the field widths
   assign master_sum = pty_pkg::SUM_W'(out_fill);
   assign slave_sum  = pty_pkg::SUM_W'(in_fill) + pty_pkg::SUM_W'(len_ff - pos_ff);
   assign rsp_payload.status         = status_ff;
   assign rsp_payload.read_data      = rd_ff;
   assign rsp_payload.master_pending = master_sum[11:0];
   assign rsp_payload.slave_pending  = slave_sum[12:0];

   // master-side CR/LF mapping, done at accept
   always_comb begin
      mapped = req_payload.data;
      if (req_payload.opcode == pty_pkg::OP_MASTER_WRITE) begin
         if (map_cr_ff && req_payload.data == pty_pkg::CHAR_CR) begin
            mapped = pty_pkg::CHAR_LF;
         end else if (map_nl_ff && req_payload.data == pty_pkg::CHAR_LF) begin
            mapped = pty_pkg::CHAR_CR;
         end
      end
   end

   // echo bytes for the latched master byte
   always_comb begin
      echo1    = data_ff;
      echo2    = 8'h00;
      echo_two = 1'b0;
      if (data_ff == pty_pkg::CHAR_CR || data_ff == pty_pkg::CHAR_LF) begin
         echo1    = pty_pkg::CHAR_CR;
         echo2    = pty_pkg::CHAR_LF;
         echo_two = 1'b1;
      end else if (data_ff < pty_pkg::CHAR_SPACE && data_ff != pty_pkg::CHAR_TAB) begin
         echo1    = pty_pkg::CHAR_CARET;
         echo2    = pty_pkg::CHAR_AT + data_ff;
         echo_two = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      src_in      = src_ff;
      in_head_in  = in_head_ff;
      in_tail_in  = in_tail_ff;
      out_head_in = out_head_ff;
      out_tail_in = out_tail_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      scan_idx_in = scan_idx_ff;
      scan_cnt_in = scan_cnt_ff;
      op_in       = op_ff;
      data_in     = data_ff;
      second_in   = second_ff;
      status_in   = status_ff;
      rd_in       = rd_ff;
      in_we       = 1'b0;
      in_waddr    = in_head_ff;
      in_wdata    = data_ff;
      in_raddr    = in_tail_ff;
      out_we      = 1'b0;
      out_waddr   = out_head_ff;
      out_wdata   = data_ff;
      out_raddr   = out_tail_ff;
      line_we     = 1'b0;
      line_waddr  = len_ff;
      line_wdata  = in_rdata;
      line_raddr  = pos_ff;

      unique case (state_ff)
         pty_pkg::ST_IDLE: begin
            if (start) begin
               op_in     = req_payload.opcode;
               data_in   = mapped;
               status_in = pty_pkg::STATUS_DONE;
               rd_in     = 8'h00;
               state_in  = pty_pkg::ST_EXEC;
            end
         end
         pty_pkg::ST_EXEC: begin
            unique case (op_ff)
               pty_pkg::OP_MASTER_WRITE: begin
                  if (!in_full) begin
                     in_we      = 1'b1;
                     in_head_in = pty_pkg::next_idx(in_head_ff);
                  end
                  state_in = pty_pkg::ST_RESP;
                  if (echo_ff) begin
                     out_wdata = echo1;
                     if (!out_full) begin
                        out_we      = 1'b1;
                        out_head_in = pty_pkg::next_idx(out_head_ff);
                     end
                     if (echo_two) begin
                        second_in = echo2;
                        state_in  = pty_pkg::ST_SECOND;
                     end
                  end
               end
               pty_pkg::OP_SLAVE_WRITE: begin
                  state_in = pty_pkg::ST_RESP;
                  if (crnl_ff && data_ff == pty_pkg::CHAR_LF) begin
                     out_wdata = pty_pkg::CHAR_CR;
                     second_in = data_ff;
                     state_in  = pty_pkg::ST_SECOND;
                  end
                  if (!out_full) begin
                     out_we      = 1'b1;
                     out_head_in = pty_pkg::next_idx(out_head_ff);
                  end
               end
               pty_pkg::OP_MASTER_READ: begin
                  if (out_fill == '0) begin
                     status_in = pty_pkg::STATUS_EMPTY;
                     state_in  = pty_pkg::ST_RESP;
                  end else begin
                     out_tail_in = pty_pkg::next_idx(out_tail_ff);
                     src_in      = pty_pkg::SRC_OUT;
                     state_in    = pty_pkg::ST_POP_WAIT;
                  end
               end
               pty_pkg::OP_SLAVE_READ: begin
                  if (!canon_ff) begin
                     if (in_fill == '0) begin
                        status_in = pty_pkg::STATUS_EMPTY;
                        state_in  = pty_pkg::ST_RESP;
                     end else begin
                        in_tail_in = pty_pkg::next_idx(in_tail_ff);
                        src_in     = pty_pkg::SRC_IN;
                        state_in   = pty_pkg::ST_POP_WAIT;
                     end
                  end else if (pos_ff < len_ff) begin
                     pos_in   = pos_ff + 1'b1;
                     src_in   = pty_pkg::SRC_LINE;
                     state_in = pty_pkg::ST_POP_WAIT;
                  end else if (in_fill == '0) begin
                     status_in = pty_pkg::STATUS_EMPTY;
                     state_in  = pty_pkg::ST_RESP;
                  end else begin
                     scan_idx_in = in_tail_ff;
                     scan_cnt_in = in_fill;
                     state_in    = pty_pkg::ST_SCAN_RD;
                  end
               end
               default: state_in = pty_pkg::ST_RESP;
            endcase
         end
         pty_pkg::ST_SECOND: begin
            out_wdata = second_ff;
            if (!out_full) begin
               out_we      = 1'b1;
               out_head_in = pty_pkg::next_idx(out_head_ff);
            end
            state_in = pty_pkg::ST_RESP;
         end
         pty_pkg::ST_POP_WAIT: begin
            unique case (src_ff)
               pty_pkg::SRC_OUT:  rd_in = out_rdata;
               pty_pkg::SRC_IN:   rd_in = in_rdata;
               pty_pkg::SRC_LINE: rd_in = line_rdata;
               default:           rd_in = 8'h00;
            endcase
            state_in = pty_pkg::ST_RESP;
         end
         // look for a terminator without consuming anything
         pty_pkg::ST_SCAN_RD: begin
            in_raddr = scan_idx_ff;
            state_in = pty_pkg::ST_SCAN_CHK;
         end
         pty_pkg::ST_SCAN_CHK: begin
            if (in_rdata == pty_pkg::CHAR_LF || in_rdata == eof_ff) begin
               len_in   = '0;
               pos_in   = '0;
               state_in = pty_pkg::ST_ASM_RD;
            end else begin
               scan_idx_in = pty_pkg::next_idx(scan_idx_ff);
               scan_cnt_in = scan_cnt_ff - 1'b1;
               if (scan_cnt_ff == pty_pkg::FILL_W'(1)) begin
                  status_in = pty_pkg::STATUS_EMPTY;
                  state_in  = pty_pkg::ST_RESP;
               end else begin
                  state_in = pty_pkg::ST_SCAN_RD;
               end
            end
         end
         // pop and edit into the line store
         pty_pkg::ST_ASM_RD: begin
            if (in_head_ff == in_tail_ff) begin
               state_in = pty_pkg::ST_FIN;
            end else begin
               in_tail_in = pty_pkg::next_idx(in_tail_ff);
               state_in   = pty_pkg::ST_ASM_CHK;
            end
         end
         pty_pkg::ST_ASM_CHK: begin
            priority if (in_rdata == erase_ff) begin
               if (len_ff != '0) begin
                  len_in = len_ff - 1'b1;
               end
               state_in = pty_pkg::ST_ASM_RD;
            end else if (in_rdata == kill_ff) begin
               len_in   = '0;
               state_in = pty_pkg::ST_ASM_RD;
            end else if (in_rdata == eof_ff) begin
               state_in = pty_pkg::ST_FIN;
            end else begin
               line_we  = 1'b1;
               len_in   = len_ff + 1'b1;
               state_in = (in_rdata == pty_pkg::CHAR_LF) ? pty_pkg::ST_FIN
                                                         : pty_pkg::ST_ASM_RD;
            end
         end
         pty_pkg::ST_FIN: begin
            if (len_ff == '0) begin
               status_in = pty_pkg::STATUS_EOF;
               state_in  = pty_pkg::ST_RESP;
            end else begin
               line_raddr = '0;
               pos_in     = pty_pkg::AW'(1);
               src_in     = pty_pkg::SRC_LINE;
               state_in   = pty_pkg::ST_POP_WAIT;
            end
         end
         pty_pkg::ST_RESP: state_in = pty_pkg::ST_IDLE;
         default:          state_in = pty_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pty_pkg::ST_IDLE;
         in_head_ff  <= '0;
         in_tail_ff  <= '0;
         out_head_ff <= '0;
         out_tail_ff <= '0;
         len_ff      <= '0;
         pos_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         in_head_ff  <= in_head_in;
         in_tail_ff  <= in_tail_in;
         out_head_ff <= out_head_in;
         out_tail_ff <= out_tail_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      scan_idx_ff <= scan_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      op_ff       <= op_in;
      data_ff     <= data_in;
      second_ff   <= second_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
   end

   // configuration transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_cr_ff <= 1'b1;
         map_nl_ff <= 1'b0;
         crnl_ff   <= 1'b1;
         canon_ff  <= 1'b1;
         echo_ff   <= 1'b1;
         erase_ff  <= 8'd127;
         kill_ff   <= 8'd21;
         eof_ff    <= 8'd4;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pty_pkg::REG_MAP_CR_TO_NL:   map_cr_ff <= csr_data[0];
            pty_pkg::REG_MAP_NL_TO_CR:   map_nl_ff <= csr_data[0];
            pty_pkg::REG_OUT_NL_TO_CRNL: crnl_ff   <= csr_data[0];
            pty_pkg::REG_CANONICAL_MODE: canon_ff  <= csr_data[0];
            pty_pkg::REG_ECHO_ENABLE:    echo_ff   <= csr_data[0];
            pty_pkg::REG_ERASE_CHAR:     erase_ff  <= csr_data;
            pty_pkg::REG_KILL_CHAR:      kill_ff   <= csr_data;
            pty_pkg::REG_EOF_CHAR:       eof_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   `PTY_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `PTY_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command accepted but not busy")
   `PTY_ASSERT_NOW(a_status_code, rsp_valid, rsp_payload.status <= pty_pkg::STATUS_EOF, "bad status code")
   `PTY_ASSERT_NOW(a_line_pos, state_ff == pty_pkg::ST_IDLE, pos_ff <= len_ff, "line position past length")
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the pseudoterminal byte engine pty_line_discipline.
`timescale 1ns / 1ps

module testbench;
   localparam int DEPTH = 4096;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   pty_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   pty_pkg::rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [3:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   pty_line_discipline u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the engine: rings, held line and register copies
   // ---------------------------------------------------------------------
   logic [7:0] in_bytes [DEPTH];
   logic [7:0] out_bytes [DEPTH];
   logic [7:0] held_line [DEPTH];
   int in_wr, in_rd, out_wr, out_rd;
   int held_len, held_pos;
   logic cr_to_nl, nl_to_cr, crnl_out, canon, echo_on;
   logic [7:0] erase_c, kill_c, eof_c;

   pty_pkg::rsp_type expected_rsps[$];
   int      failures = 0;
   bit      gaps_on = 1'b1;

   function automatic int occupancy(int wr, int rd);
      return (wr >= rd) ? wr - rd : wr + DEPTH - rd;
   endfunction

   // A full ring (DEPTH-1 bytes) drops the pushed byte
   function automatic void push_input(logic [7:0] c);
      if (occupancy(in_wr, in_rd) >= DEPTH - 1) return;
      in_bytes[in_wr] = c;
      in_wr = (in_wr + 1) % DEPTH;
   endfunction

   function automatic void push_output(logic [7:0] c);
      if (occupancy(out_wr, out_rd) >= DEPTH - 1) return;
      out_bytes[out_wr] = c;
      out_wr = (out_wr + 1) % DEPTH;
   endfunction

   function automatic void echo_master(logic [7:0] c);
      if (!echo_on) return;
      if (c == pty_pkg::CHAR_CR || c == pty_pkg::CHAR_LF) begin
         push_output(pty_pkg::CHAR_CR);
         push_output(pty_pkg::CHAR_LF);
      end else if (c < pty_pkg::CHAR_SPACE && c != pty_pkg::CHAR_TAB) begin
         push_output(pty_pkg::CHAR_CARET);
         push_output(pty_pkg::CHAR_AT + c);
      end else begin
         push_output(c);
      end
   endfunction

   // Is there an LF or EOF byte anywhere in the input ring?
   function automatic bit complete_line_waiting();
      int i;
      i = in_rd;
      while (i != in_wr) begin
         if (in_bytes[i] == pty_pkg::CHAR_LF || in_bytes[i] == eof_c) return 1'b1;
         i = (i + 1) % DEPTH;
      end
      return 1'b0;
   endfunction

   // Edit one line out of the input ring: erase, then kill, then EOF, then store
   function automatic void take_line();
      int n;
      logic [7:0] c;
      n = 0;
      while (in_rd != in_wr) begin
         c = in_bytes[in_rd];
         in_rd = (in_rd + 1) % DEPTH;
         if (c == erase_c) begin
            if (n > 0) n--;
            continue;
         end
         if (c == kill_c) begin
            n = 0;
            continue;
         end
         if (c == eof_c) break;
         if (n < DEPTH) begin
            held_line[n] = c;
            n++;
         end
         if (c == pty_pkg::CHAR_LF) break;
      end
      held_len = n;
      held_pos = 0;
   endfunction

   function automatic pty_pkg::rsp_type line_engine(pty_pkg::req_type r);
      pty_pkg::rsp_type o;
      logic [7:0] d;
      o = '0;
      o.status = pty_pkg::STATUS_DONE;
      d = r.data;
      case (r.opcode)
         pty_pkg::OP_MASTER_WRITE: begin
            if (cr_to_nl && d == pty_pkg::CHAR_CR) d = pty_pkg::CHAR_LF;
            else if (nl_to_cr && d == pty_pkg::CHAR_LF) d = pty_pkg::CHAR_CR;
            push_input(d);
            echo_master(d);
         end
         pty_pkg::OP_SLAVE_WRITE: begin
            if (crnl_out && d == pty_pkg::CHAR_LF) push_output(pty_pkg::CHAR_CR);
            push_output(d);
         end
         pty_pkg::OP_MASTER_READ: begin
            if (out_rd == out_wr) o.status = pty_pkg::STATUS_EMPTY;
            else begin
               o.read_data = out_bytes[out_rd];
               out_rd = (out_rd + 1) % DEPTH;
            end
         end
         default: begin
            if (!canon) begin
               // raw reads leave any held line alone
               if (in_rd == in_wr) o.status = pty_pkg::STATUS_EMPTY;
               else begin
                  o.read_data = in_bytes[in_rd];
                  in_rd = (in_rd + 1) % DEPTH;
               end
            end else begin
               if (held_pos >= held_len) begin
                  if (!complete_line_waiting()) o.status = pty_pkg::STATUS_EMPTY;
                  else begin
                     take_line();
                     if (held_len == 0) o.status = pty_pkg::STATUS_EOF;
                  end
               end
               if (o.status == pty_pkg::STATUS_DONE && held_pos < held_len) begin
                  o.read_data = held_line[held_pos];
                  held_pos++;
               end
            end
         end
      endcase
      o.master_pending = 12'(occupancy(out_wr, out_rd));
      o.slave_pending  = 13'(occupancy(in_wr, in_rd) + held_len - held_pos);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: one strobe, one transfer, oldest expectation first
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pty_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result %h", rsp_payload);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_payload.status);
               failures++;
            end
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %h actual %h",
                      want.read_data, rsp_payload.read_data);
               failures++;
            end
            if (rsp_payload.master_pending !== want.master_pending) begin
               $error("master_pending: expected %0d actual %0d",
                      want.master_pending, rsp_payload.master_pending);
               failures++;
            end
            if (rsp_payload.slave_pending !== want.slave_pending) begin
               $error("slave_pending: expected %0d actual %0d",
                      want.slave_pending, rsp_payload.slave_pending);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   function automatic int idle_gap();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // One command transfer; start is left high so back-to-back items need no
   // second assignment in the same step.
   task automatic send_cmd(logic [1:0] op, logic [7:0] d);
      int gap;
      pty_pkg::req_type r;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.opcode = op;
      r.data   = d;
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(line_engine(r));
   endtask

   // Sender holds off until every outstanding result has come back
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0 || busy);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [7:0] val);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pty_pkg::REG_MAP_CR_TO_NL:   cr_to_nl = val[0];
         pty_pkg::REG_MAP_NL_TO_CR:   nl_to_cr = val[0];
         pty_pkg::REG_OUT_NL_TO_CRNL: crnl_out = val[0];
         pty_pkg::REG_CANONICAL_MODE: canon    = val[0];
         pty_pkg::REG_ECHO_ENABLE:    echo_on  = val[0];
         pty_pkg::REG_ERASE_CHAR:     erase_c  = val;
         pty_pkg::REG_KILL_CHAR:      kill_c   = val;
         pty_pkg::REG_EOF_CHAR:       eof_c    = val;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Mapping, echo forms, slave CRLF, editing, EOF and the empty answers
   task automatic test_directed();
      send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);      // no line yet
      send_cmd(pty_pkg::OP_MASTER_READ, 8'h00);     // output empty
      send_cmd(pty_pkg::OP_MASTER_WRITE, "a");
      send_cmd(pty_pkg::OP_MASTER_WRITE, "b");
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'h7F);    // erase
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'h00);    // caret form
      send_cmd(pty_pkg::OP_MASTER_WRITE, pty_pkg::CHAR_TAB); // raw echo
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'hFF);
      send_cmd(pty_pkg::OP_MASTER_WRITE, pty_pkg::CHAR_CR);  // mapped to LF, CR LF echo
      repeat (5) send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      send_cmd(pty_pkg::OP_MASTER_WRITE, "z");
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'd21);    // kill
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'd4);     // eof on empty line
      send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      send_cmd(pty_pkg::OP_SLAVE_WRITE, pty_pkg::CHAR_LF);
      send_cmd(pty_pkg::OP_SLAVE_WRITE, 8'h1F);
      repeat (14) send_cmd(pty_pkg::OP_MASTER_READ, 8'h00);
      wait_quiet();
   endtask

   // Held line survives a spell in raw mode; LF and CR mapping the other way
   task automatic test_held_line_raw();
      write_reg(pty_pkg::REG_MAP_CR_TO_NL, 8'h00);
      write_reg(pty_pkg::REG_MAP_NL_TO_CR, 8'h01);
      write_reg(pty_pkg::REG_ECHO_ENABLE, 8'h00);
      write_reg(pty_pkg::REG_OUT_NL_TO_CRNL, 8'h00);
      send_cmd(pty_pkg::OP_MASTER_WRITE, "x");
      send_cmd(pty_pkg::OP_MASTER_WRITE, pty_pkg::CHAR_LF);  // becomes CR, no terminator
      send_cmd(pty_pkg::OP_MASTER_WRITE, 8'd4);
      send_cmd(pty_pkg::OP_MASTER_WRITE, "p");
      send_cmd(pty_pkg::OP_SLAVE_WRITE, pty_pkg::CHAR_LF);
      send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      write_reg(pty_pkg::REG_CANONICAL_MODE, 8'h00);
      repeat (3) send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      write_reg(pty_pkg::REG_CANONICAL_MODE, 8'h01);
      repeat (3) send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      send_cmd(pty_pkg::OP_MASTER_READ, 8'h00);
      // erase equal to LF eats the terminator: empty line
      write_reg(pty_pkg::REG_ERASE_CHAR, pty_pkg::CHAR_LF);
      write_reg(pty_pkg::REG_MAP_NL_TO_CR, 8'h00);
      send_cmd(pty_pkg::OP_MASTER_WRITE, "q");
      send_cmd(pty_pkg::OP_MASTER_WRITE, pty_pkg::CHAR_LF);
      send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
      write_reg(pty_pkg::REG_ERASE_CHAR, 8'd127);
   endtask

   function automatic logic [7:0] line_byte();
      case ($urandom_range(0, 15))
         0, 1:    return pty_pkg::CHAR_LF;
         2:       return pty_pkg::CHAR_CR;
         3:       return erase_c;
         4:       return kill_c;
         5:       return eof_c;
         6:       return 8'($urandom_range(0, 31));
         7:       return 8'($urandom);
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic logic [7:0] reg_value(int idx);
      if (idx < 5) return 8'($urandom);
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'($urandom);
         3:       return 8'd127;
         4:       return 8'd21;
         default: return 8'd4;
      endcase
   endfunction

   // Phases of typed lines read back in part or whole, with noise in between
   task automatic test_random_sessions();
      int n, k, j, m;
      for (int ph = 0; ph < 8; ph++) begin
         for (int r = 0; r < 8; r++) write_reg(4'(r), reg_value(r));
         write_reg(4'($urandom_range(8, 15)), 8'($urandom)); // ignored index
         if (ph == 0) write_reg(pty_pkg::REG_CANONICAL_MODE, 8'h01);
         gaps_on = (ph % 3 != 1);
         n = 0;
         while (n < 95) begin
            if ($urandom_range(0, 4) != 0) begin
               k = $urandom_range(1, 8);
               j = $urandom_range(1, k + 2);
               m = $urandom_range(0, 2 * k);
               repeat (k) send_cmd(pty_pkg::OP_MASTER_WRITE, line_byte());
               send_cmd(pty_pkg::OP_MASTER_WRITE, pty_pkg::CHAR_LF);
               repeat (j) send_cmd(pty_pkg::OP_SLAVE_READ, 8'h00);
               repeat (m) send_cmd(pty_pkg::OP_MASTER_READ, 8'h00);
               n += k + 1 + j + m;
            end else begin
               send_cmd(2'($urandom), 8'($urandom));
               n++;
            end
         end
         if (ph == 4) wait_quiet();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      in_wr = 0; in_rd = 0; out_wr = 0; out_rd = 0;
      held_len = 0; held_pos = 0;
      cr_to_nl = 1'b1; nl_to_cr = 1'b0; crnl_out = 1'b1; canon = 1'b1; echo_on = 1'b1;
      erase_c = 8'd127; kill_c = 8'd21; eof_c = 8'd4;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_held_line_raw();
      test_random_sessions();

      wait_quiet();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200_000_000;
      $display("testbench: FAIL");
      $finish;
   end
endmodule
